// ===== rtl/trrb_pkg.sv =====
// ----------------------------------------------------------------------------
// trrb_pkg
// Shared types and constants for the round-robin barrier scheduler.
// ----------------------------------------------------------------------------
package trrb_pkg;

    localparam int MAX_THREADS = 32;
    localparam int TID_W       = $clog2(MAX_THREADS);
    localparam int PICK_W      = $clog2(MAX_THREADS + 1);
    localparam int CNT_W       = 6;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    typedef enum logic [1:0] {
        KIND_PICK    = 2'd0,
        KIND_BLOCK   = 2'd1,
        KIND_FINISH  = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic {
        REG_SCHED_MODE   = 1'b0,
        REG_THREAD_COUNT = 1'b1
    } reg_idx_t;

    typedef logic [MAX_THREADS-1:0] mask_t;

    typedef struct packed {
        kind_t            kind;
        logic [TID_W-1:0] thread_id;
    } evt_t;

    typedef struct packed {
        logic [TID_W-1:0] chosen_thread;
        logic             barrier_wake;
        logic             none_live;
    } res_t;

    typedef struct packed {
        logic             sched_mode;
        logic [CNT_W-1:0] thread_count;
    } cfg_t;

    typedef struct packed {
        mask_t live;
        mask_t active;
    } sts_t;

endpackage

// ===== rtl/trrb_if.sv =====
// ----------------------------------------------------------------------------
// trrb_evt_if / trrb_res_if
// Valid/ready channels for scheduler events and results.
// ----------------------------------------------------------------------------
interface trrb_evt_if;
    import trrb_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [TID_W-1:0] thread_id;

    modport source (output valid, output kind, output thread_id, input ready);
    modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

interface trrb_res_if;
    import trrb_pkg::*;

    logic             valid;
    logic             ready;
    logic [TID_W-1:0] chosen_thread;
    logic             barrier_wake;
    logic             none_live;

    modport source (output valid, output chosen_thread, output barrier_wake,
                    output none_live, input ready);
    modport sink   (input valid, input chosen_thread, input barrier_wake,
                    input none_live, output ready);
endinterface

// ===== rtl/thread_round_robin_barrier_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// thread_round_robin_barrier_scheduler_unit
// Round-robin thread scheduler with barrier release, APB configured.
// ----------------------------------------------------------------------------
// One event is taken per clock while results are accepted. An event register
// feeds the scheduler state update and the result register in the same cycle,
// so a transferred event passes through the event register and then the result
// register before its result is presented. The sustained rate is one event per
// cycle while results are accepted, set by the combinational masked priority
// encoder over the active mask that updates the pick. Results wait in the result
// register while a further event is still taken into the event register. No
// clearing pass follows reset.
module thread_round_robin_barrier_scheduler_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    trrb_evt_if.sink                     evt,
    trrb_res_if.source                   res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [trrb_pkg::APB_AW-1:0]  paddr,
    input  logic [trrb_pkg::APB_DW-1:0]  pwdata,
    output logic [trrb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import trrb_pkg::*;

    cfg_t  cfg;
    evt_t  evt_reg;
    logic  in_vld_reg;
    res_t  out_reg;
    logic  out_vld_reg;
    res_t  core_res;
    sts_t  sts;
    logic  adv;
    logic  take;

    trrb_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign adv       = in_vld_reg && (!out_vld_reg || res.ready);
    assign evt.ready = !in_vld_reg || adv;
    assign take      = evt.valid && evt.ready;

    trrb_sched_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (adv),
        .evt   (evt_reg),
        .cfg   (cfg),
        .res   (core_res),
        .sts   (sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= take || (in_vld_reg && !adv);
            if (adv)
                out_vld_reg <= 1'b1;
            else if (res.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            evt_reg.kind      <= kind_t'(evt.kind);
            evt_reg.thread_id <= evt.thread_id;
        end
        if (adv)
            out_reg <= core_res;
    end

    assign res.valid         = out_vld_reg;
    assign res.chosen_thread = out_reg.chosen_thread;
    assign res.barrier_wake  = out_reg.barrier_wake;
    assign res.none_live     = out_reg.none_live;

    // a thread can only be active while it is live
    a_active_in_live: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.active & ~sts.live) == '0)
        else $error("active thread that is not live");

    // a held event is never dropped while the result side stalls
    a_hold_evt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !adv) |=> in_vld_reg)
        else $error("pending event lost");

    // a transfer out of the event register always produces a result
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_vld_reg)
        else $error("result missing after advance");

    // a result cannot report both a barrier release and no live thread
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(out_reg.barrier_wake && out_reg.none_live))
        else $error("conflicting result flags");

endmodule

// ===== rtl/trrb_apb_regs.sv =====
// ----------------------------------------------------------------------------
// trrb_apb_regs
// APB register file: scheduling mode and restart thread count.
// ----------------------------------------------------------------------------
module trrb_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [trrb_pkg::APB_AW-1:0]  paddr,
    input  logic [trrb_pkg::APB_DW-1:0]  pwdata,
    output logic [trrb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output trrb_pkg::cfg_t               cfg
);
    import trrb_pkg::*;

    logic             mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr_en;
    reg_idx_t         idx;

    // registers sit on 4-byte boundaries
    assign idx    = reg_idx_t'(paddr[2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= CNT_W'(MAX_THREADS);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SCHED_MODE:   mode_reg  <= pwdata[0];
                REG_THREAD_COUNT: count_reg <= pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SCHED_MODE:   prdata = APB_DW'(mode_reg);
            REG_THREAD_COUNT: prdata = APB_DW'(count_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.sched_mode   = mode_reg;
    assign cfg.thread_count = count_reg;

endmodule

// ===== rtl/trrb_rr_search.sv =====
// ----------------------------------------------------------------------------
// trrb_rr_search
// Masked priority encoder: next active thread above the pick, else lowest.
// ----------------------------------------------------------------------------
module trrb_rr_search (
    input  trrb_pkg::mask_t                active,
    input  logic [trrb_pkg::PICK_W-1:0]    pick,
    output logic [trrb_pkg::TID_W-1:0]     next
);
    import trrb_pkg::*;

    mask_t            above;
    logic [TID_W-1:0] idx_hi;
    logic [TID_W-1:0] idx_lo;

    always_comb
    begin
        above  = '0;
        idx_hi = '0;
        idx_lo = '0;
        for (int i = 0; i < MAX_THREADS; i++)
            above[i] = active[i] && (PICK_W'(i) > pick);
        // walk down so the lowest set bit wins
        for (int i = MAX_THREADS - 1; i >= 0; i--)
        begin
            if (above[i])
                idx_hi = TID_W'(i);
            if (active[i])
                idx_lo = TID_W'(i);
        end
        next = (|above) ? idx_hi : idx_lo;
    end

endmodule

// ===== rtl/trrb_sched_core.sv =====
// ----------------------------------------------------------------------------
// trrb_sched_core
// Live/active masks and current pick; applies one event per advance.
// ----------------------------------------------------------------------------
module trrb_sched_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  trrb_pkg::evt_t  evt,
    input  trrb_pkg::cfg_t  cfg,
    output trrb_pkg::res_t  res,
    output trrb_pkg::sts_t  sts
);
    import trrb_pkg::*;

    mask_t             live_reg,   live_next;
    mask_t             active_reg, active_next;
    logic [PICK_W-1:0] pick_reg,   pick_next;
    mask_t             act_eff;
    mask_t             start_mask;
    logic [PICK_W-1:0] start_n;
    logic [TID_W-1:0]  rr_next;
    logic              keep;

    // barrier release: an empty active set reloads from live
    assign act_eff = (active_reg == '0) ? live_reg : active_reg;

    trrb_rr_search u_rr (
        .active (act_eff),
        .pick   (pick_reg),
        .next   (rr_next)
    );

    always_comb
    begin
        start_n = (cfg.thread_count > CNT_W'(MAX_THREADS)) ? PICK_W'(MAX_THREADS)
                                                           : PICK_W'(cfg.thread_count);
        for (int i = 0; i < MAX_THREADS; i++)
            start_mask[i] = PICK_W'(i) < start_n;

        keep = cfg.sched_mode && (pick_reg < PICK_W'(MAX_THREADS)) &&
               act_eff[pick_reg[TID_W-1:0]];

        live_next   = live_reg;
        active_next = active_reg;
        pick_next   = pick_reg;
        res         = '0;

        case (evt.kind)
            KIND_PICK:
            begin
                if (live_reg == '0)
                    res.none_live = 1'b1;
                else
                begin
                    res.barrier_wake  = (active_reg == '0);
                    active_next       = act_eff;
                    pick_next         = keep ? pick_reg : PICK_W'(rr_next);
                    res.chosen_thread = pick_next[TID_W-1:0];
                end
            end
            KIND_BLOCK:
                active_next[evt.thread_id] = 1'b0;
            KIND_FINISH:
            begin
                active_next[evt.thread_id] = 1'b0;
                live_next[evt.thread_id]   = 1'b0;
            end
            KIND_RESTART:
            begin
                live_next   = live_reg | start_mask;
                active_next = active_reg | start_mask;
                pick_next   = cfg.sched_mode ? '0 : start_n;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= '0;
            active_reg <= '0;
            pick_reg   <= '0;
        end
        else if (fire)
        begin
            live_reg   <= live_next;
            active_reg <= active_next;
            pick_reg   <= pick_next;
        end
    end

    assign sts.live   = live_reg;
    assign sts.active = active_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin barrier thread scheduler.
// Events are pushed through the valid/ready event channel with random idling,
// a bench-side scheduler model predicts each result at the event transfer, and
// every result transfer is checked field by field against the oldest
// prediction. Mode and thread count are changed over APB between phases.
// ----------------------------------------------------------------------------
module tb;
    import trrb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 34;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    trrb_evt_if evt_ch ();
    trrb_res_if res_ch ();

    thread_round_robin_barrier_scheduler_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // scheduler model state and register copies
    logic                 mode_q;
    logic [CNT_W-1:0]     count_q;
    mask_t                live_q;
    mask_t                active_q;
    logic [PICK_W-1:0]    pick_q;

    evt_t    pending_evts[$];
    res_t    sched_results[$];
    int      fails;
    int      stall_cycles;
    int      evt_total;
    bit      evt_taken;
    bit      idling;
    bit      moved;
    res_t    got_r;
    res_t    want_r;

    function automatic res_t predict_sched(evt_t e);
        res_t              r;
        int                n;
        int                nxt;
        mask_t             fill;
        r = '0;
        case (e.kind)
            KIND_PICK:
            begin
                if (live_q == '0)
                    r.none_live = 1'b1;
                else
                begin
                    // barrier release: everyone blocked, wake all live threads
                    if (active_q == '0)
                    begin
                        active_q       = live_q;
                        r.barrier_wake = 1'b1;
                    end
                    if (!(mode_q && pick_q < MAX_THREADS && active_q[pick_q]))
                    begin
                        nxt = -1;
                        for (int i = MAX_THREADS - 1; i >= 0; i--)
                            if (active_q[i] && i > int'(pick_q))
                                nxt = i;
                        if (nxt < 0)
                            for (int i = MAX_THREADS - 1; i >= 0; i--)
                                if (active_q[i])
                                    nxt = i;
                        pick_q = PICK_W'(nxt);
                    end
                    r.chosen_thread = pick_q[TID_W-1:0];
                end
            end
            KIND_BLOCK, KIND_FINISH:
            begin
                active_q[e.thread_id] = 1'b0;
                if (e.kind == KIND_FINISH)
                    live_q[e.thread_id] = 1'b0;
            end
            default:
            begin
                n = (count_q > MAX_THREADS) ? MAX_THREADS : int'(count_q);
                fill = '0;
                for (int i = 0; i < n; i++)
                    fill[i] = 1'b1;
                live_q   = live_q | fill;
                active_q = active_q | fill;
                pick_q   = mode_q ? '0 : PICK_W'(n);
            end
        endcase
        return r;
    endfunction

    function automatic bit take_break();
        return idling && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // drive on the falling edge; a valid that was not taken is held as is
    always @(negedge clk)
    begin
        if (!(evt_ch.valid && !evt_taken))
        begin
            if (rst_n && pending_evts.size() > 0 && !take_break())
            begin
                evt_ch.valid     <= 1'b1;
                evt_ch.kind      <= pending_evts[0].kind;
                evt_ch.thread_id <= pending_evts[0].thread_id;
            end
            else
                evt_ch.valid <= 1'b0;
        end
        res_ch.ready <= !take_break();
    end

    // event transfers, result checks and watchdog, all sampled at the rising edge
    always @(posedge clk)
    begin
        moved = 1'b0;
        evt_taken = 1'b0;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            evt_taken = 1'b1;
            moved     = 1'b1;
            void'(pending_evts.pop_front());
            sched_results.insert(sched_results.size(),
                                 predict_sched(evt_t'{kind_t'(evt_ch.kind),
                                                      evt_ch.thread_id}));
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            moved = 1'b1;
            got_r = res_t'{res_ch.chosen_thread, res_ch.barrier_wake, res_ch.none_live};
            if (sched_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer: expected none, actual %p",
                         $time, got_r);
                fails++;
            end
            else
            begin
                want_r = sched_results.pop_front();
                if (got_r.chosen_thread !== want_r.chosen_thread)
                begin
                    $display("%0t: chosen_thread expected %0d actual %0d",
                             $time, want_r.chosen_thread, got_r.chosen_thread);
                    fails++;
                end
                if (got_r.barrier_wake !== want_r.barrier_wake)
                begin
                    $display("%0t: barrier_wake expected %0b actual %0b",
                             $time, want_r.barrier_wake, got_r.barrier_wake);
                    fails++;
                end
                if (got_r.none_live !== want_r.none_live)
                begin
                    $display("%0t: none_live expected %0b actual %0b",
                             $time, want_r.none_live, got_r.none_live);
                    fails++;
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d events pending, %0d results outstanding",
                     $time, pending_evts.size(), sched_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_SCHED_MODE)
            mode_q = val[0];
        else
            count_q = val[CNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_evt(kind_t k, logic [TID_W-1:0] tid);
        pending_evts.insert(pending_evts.size(), evt_t'{k, tid});
        evt_total++;
    endtask

    // let the block go quiet before touching registers
    task automatic drain();
        while (pending_evts.size() != 0 || sched_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic finish_sweep();
        for (int t = 0; t < MAX_THREADS; t++)
            push_evt(KIND_FINISH, TID_W'(t));
    endtask

    // block (or finish) threads 0 to n-1 in random order, interleaved with picks,
    // an occasional restart and random events, then pick again so the barrier releases
    task automatic barrier_round(int n);
        int ids[$];
        int j;
        int tmp;
        int r;
        for (int t = 0; t < n; t++)
            ids.insert(ids.size(), t);
        for (int t = n - 1; t > 0; t--)
        begin
            j = $urandom_range(t);
            tmp = ids[t];
            ids[t] = ids[j];
            ids[j] = tmp;
        end
        if ($urandom_range(3) == 0)
            push_evt(KIND_RESTART, TID_W'($urandom));
        foreach (ids[t])
        begin
            if ($urandom_range(1) == 0)
                push_evt(KIND_PICK, TID_W'($urandom));
            r = $urandom_range(99);
            if (r < 8)
                push_evt(kind_t'($urandom_range(3)), TID_W'($urandom));
            else if (r < 20)
                push_evt(KIND_FINISH, TID_W'(ids[t]));
            else
                push_evt(KIND_BLOCK, TID_W'(ids[t]));
        end
        push_evt(KIND_PICK, TID_W'($urandom));
        push_evt(KIND_PICK, TID_W'($urandom));
    endtask

    task automatic random_phase(logic m, logic [CNT_W-1:0] cnt, int items);
        int stop_at;
        int n;
        apb_write(REG_SCHED_MODE, APB_DW'(m));
        apb_write(REG_THREAD_COUNT, APB_DW'(cnt));
        stop_at = evt_total + items;
        finish_sweep();
        push_evt(KIND_RESTART, '0);
        while (evt_total < stop_at)
        begin
            n = (cnt > MAX_THREADS) ? MAX_THREADS : int'(cnt);
            case ($urandom_range(9))
                0:
                begin
                    finish_sweep();
                    push_evt(KIND_RESTART, TID_W'($urandom));
                end
                1:
                    repeat (20)
                        push_evt(kind_t'($urandom_range(3)), TID_W'($urandom));
                default:
                    barrier_round((n > 1 && $urandom_range(1)) ? $urandom_range(n, 1) : n);
            endcase
        end
        drain();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        evt_ch.valid     = 1'b0;
        evt_ch.kind      = '0;
        evt_ch.thread_id = '0;
        res_ch.ready     = 1'b0;
        mode_q           = 1'b0;
        count_q          = CNT_W'(32);
        live_q           = '0;
        active_q         = '0;
        pick_q           = '0;
        fails            = 0;
        stall_cycles     = 0;
        evt_total        = 0;
        idling           = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // nothing started yet: picks see no live thread, block/finish do nothing
        push_evt(KIND_PICK, '0);
        push_evt(KIND_BLOCK, 5'd5);
        push_evt(KIND_FINISH, '0);
        push_evt(KIND_PICK, '1);
        drain();

        // two threads, round-robin: wrap, barrier release, then run dry
        apb_write(REG_THREAD_COUNT, APB_DW'(2));
        push_evt(KIND_RESTART, '0);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_BLOCK, '0);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_BLOCK, 5'd1);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_FINISH, 5'd1);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_FINISH, '0);
        push_evt(KIND_PICK, '0);
        drain();

        // sequential mode, oversized count saturates to all threads
        apb_write(REG_SCHED_MODE, APB_DW'(1));
        apb_write(REG_THREAD_COUNT, APB_DW'(63));
        push_evt(KIND_RESTART, '1);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_BLOCK, '0);
        push_evt(KIND_PICK, '1);
        push_evt(KIND_FINISH, '1);
        push_evt(KIND_PICK, '0);
        push_evt(KIND_RESTART, '0);
        push_evt(KIND_PICK, '0);
        drain();

        random_phase(1'b0, CNT_W'(32), 255);
        random_phase(1'b1, CNT_W'(1), 255);
        idling = 1'b0;
        random_phase(1'b0, CNT_W'($urandom_range(32, 1)), 255);
        idling = 1'b1;
        random_phase(1'b1, CNT_W'(32), 255);
        random_phase(1'b0, CNT_W'(1), 255);
        random_phase(1'b1, CNT_W'($urandom_range(32, 1)), 255);
        random_phase(1'b0, CNT_W'(63), 255);

        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
